// ----- hdl/ntc_pkg.sv -----
// ----------------------------------------------------------------------------
// ntc_pkg
// Shared types, codes and helpers for the numeric type converter.
// ----------------------------------------------------------------------------
package ntc_pkg;

    // size codes: 1, 2, 4, 8 bytes
    localparam logic [1:0] SZ_1B = 2'd0;
    localparam logic [1:0] SZ_2B = 2'd1;
    localparam logic [1:0] SZ_4B = 2'd2;
    localparam logic [1:0] SZ_8B = 2'd3;

    typedef enum logic [1:0] {
        MODE_II = 2'd0,   // integer to integer
        MODE_IF = 2'd1,   // integer to float
        MODE_FI = 2'd2,   // float to integer
        MODE_FF = 2'd3    // float to float
    } ntc_mode_t;

    typedef enum logic [1:0] {
        CLS_ZERO = 2'd0,
        CLS_FIN  = 2'd1,
        CLS_INF  = 2'd2,
        CLS_NAN  = 2'd3
    } ntc_cls_t;

    typedef struct packed {
        logic [63:0] value_in;
        logic        src_is_float;
        logic [1:0]  src_size_log2;
        logic        src_signed;
        logic        dst_is_float;
        logic [1:0]  dst_size_log2;
        logic        dst_signed;
    } ntc_in_t;

    typedef struct packed {
        logic [63:0] value_out;
        logic        range_flag;
        logic        type_error;
    } ntc_out_t;

    // normalized operand handed from the unpack stage to the pack stage
    typedef struct packed {
        ntc_mode_t          mode;
        logic               err;
        logic               sign;
        ntc_cls_t           cls;
        logic signed [13:0] exp;     // exponent of m[63]
        logic [63:0]        m;       // magnitude, bit 63 set unless zero
        logic [51:0]        frac;    // raw source fraction for NaN payloads
        logic [63:0]        raw;     // pass-through / int-to-int result
        logic               src_dbl;
        logic               dst_dbl;
        logic [1:0]         dst_size_log2;
        logic               dst_signed;
    } ntc_mid_t;

    function automatic logic [63:0] size_mask(input logic [1:0] sz);
        logic [63:0] r;
        case (sz)
            SZ_1B:   r = 64'h0000_0000_0000_00FF;
            SZ_2B:   r = 64'h0000_0000_0000_FFFF;
            SZ_4B:   r = 64'h0000_0000_FFFF_FFFF;
            default: r = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return r;
    endfunction

endpackage

// ----- hdl/numeric_type_converter_core.sv -----
// ----------------------------------------------------------------------------
// numeric_type_converter_core
// Integer / IEEE float conversion between 1, 2, 4 and 8 byte types.
//
//   channel  handshake             payload
//   in       in_valid / in_ready   in_data  (ntc_in_t)
//   out      out_valid / out_ready out_data (ntc_out_t)
//
// Three register stages: input, normalized operand, result; out_valid rises
// as the result register loads. One transaction per cycle unless the output
// stalls. The normalize stage (leading-one search) and the round/pack stage
// set the cycle time. Reset clears only the stage valid bits. A stalled
// output holds the pipe; in_ready falls only when every stage is full.
// ----------------------------------------------------------------------------
module numeric_type_converter_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ntc_pkg::ntc_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output ntc_pkg::ntc_out_t out_data
);
    import ntc_pkg::*;

    ntc_in_t  in_reg;
    ntc_mid_t mid_reg;
    ntc_out_t out_reg;
    ntc_mid_t mid_next;
    ntc_out_t out_next;
    logic     v0_reg, v1_reg, v2_reg;
    logic     en0, en1, en2;

    assign en2      = !v2_reg || out_ready;
    assign en1      = !v1_reg || en2;
    assign en0      = !v0_reg || en1;
    assign in_ready = en0;

    ntc_unpack u_unpack (
        .in_item (in_reg),
        .mid     (mid_next)
    );

    ntc_pack u_pack (
        .mid      (mid_reg),
        .out_item (out_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (en0)
                v0_reg <= in_valid;
            if (en1)
                v1_reg <= v0_reg;
            if (en2)
                v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en0 && in_valid)
            in_reg <= in_data;
        if (en1 && v0_reg)
            mid_reg <= mid_next;
        if (en2 && v1_reg)
            out_reg <= out_next;
    end

    assign out_valid = v2_reg;
    assign out_data  = out_reg;

    // a type error result carries nothing else
    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.type_error |-> out_data.value_out == 64'd0 &&
        !out_data.range_flag)
        else $error("type error result not clean");

    // flag only from float to integer
    a_flag_fi: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && en2 && out_next.range_flag |-> mid_reg.mode == MODE_FI)
        else $error("range flag outside float to integer");

    // back pressure only when the whole pipe is full and output stalled
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> v0_reg && v1_reg && v2_reg && !out_ready)
        else $error("input stalled with room in pipe");

    // a stalled result is not overwritten
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_reg))
        else $error("stalled result changed");

endmodule

// ----- hdl/ntc_unpack.sv -----
// ----------------------------------------------------------------------------
// ntc_unpack
// Classifies the source, takes its magnitude and normalizes it so bit 63 is
// the leading one, with the matching exponent.
// ----------------------------------------------------------------------------
module ntc_unpack (
    input  ntc_pkg::ntc_in_t  in_item,
    output ntc_pkg::ntc_mid_t mid
);
    import ntc_pkg::*;

    logic [63:0]        smask;
    logic [63:0]        v;
    logic               sdbl;
    logic               topbit;
    logic [10:0]        field;
    logic [51:0]        f;
    logic               all1;
    logic               fsign;
    logic [63:0]        mm;
    logic signed [13:0] e;
    logic               neg;
    logic [63:0]        mag;
    logic [63:0]        x;
    logic [5:0]         lz;

    always_comb
    begin
        smask = size_mask(in_item.src_size_log2);
        v     = in_item.value_in & smask;
        sdbl  = (in_item.src_size_log2 == SZ_8B);

        case (in_item.src_size_log2)
            SZ_1B:   topbit = v[7];
            SZ_2B:   topbit = v[15];
            SZ_4B:   topbit = v[31];
            default: topbit = v[63];
        endcase

        field = sdbl ? v[62:52] : {3'b0, v[30:23]};
        f     = sdbl ? v[51:0] : {29'b0, v[22:0]};
        all1  = sdbl ? (field == 11'h7FF) : (field[7:0] == 8'hFF);
        fsign = sdbl ? v[63] : v[31];

        if (field != 11'd0)
        begin
            mm = {12'b0, f} | (sdbl ? (64'd1 << 52) : (64'd1 << 23));
            e  = $signed({3'b0, field}) - (sdbl ? 14'sd1023 : 14'sd127);
        end
        else
        begin
            mm = {12'b0, f};
            e  = sdbl ? -14'sd1022 : -14'sd126;
        end

        neg = in_item.src_signed && topbit;
        mag = neg ? ((64'd0 - v) & smask) : v;
        x   = in_item.src_is_float ? mm : mag;

        // leading-one search, halving steps
        lz = 6'd0;
        for (int i = 0; i < 6; i++)
        begin
            if ((x >> (64 - (32 >> i))) == 64'd0)
            begin
                x  = x << (32 >> i);
                lz = lz | 6'(32 >> i);
            end
        end

        mid.mode          = ntc_mode_t'({in_item.src_is_float, in_item.dst_is_float});
        mid.err           = (in_item.src_is_float && in_item.src_size_log2 < SZ_4B) ||
                            (in_item.dst_is_float && in_item.dst_size_log2 < SZ_4B);
        mid.m             = x;
        mid.frac          = f;
        mid.src_dbl       = sdbl;
        mid.dst_dbl       = (in_item.dst_size_log2 == SZ_8B);
        mid.dst_size_log2 = in_item.dst_size_log2;
        mid.dst_signed    = in_item.dst_signed;

        if (in_item.src_is_float)
        begin
            mid.sign = fsign;
            mid.exp  = e + 14'sd63 - $signed({8'b0, lz}) - (sdbl ? 14'sd52 : 14'sd23);
            if (all1)
                mid.cls = (f != 52'd0) ? CLS_NAN : CLS_INF;
            else if (mm == 64'd0)
                mid.cls = CLS_ZERO;
            else
                mid.cls = CLS_FIN;
            mid.raw = v;
        end
        else
        begin
            mid.sign = neg;
            mid.exp  = 14'sd63 - $signed({8'b0, lz});
            mid.cls  = (mag == 64'd0) ? CLS_ZERO : CLS_FIN;
            mid.raw  = neg ? (v | ~smask) : v;
        end
    end

endmodule

// ----- hdl/ntc_pack.sv -----
// ----------------------------------------------------------------------------
// ntc_pack
// Rounds and packs the normalized operand into the destination format, or
// truncates and saturates it into the destination integer.
// ----------------------------------------------------------------------------
module ntc_pack (
    input  ntc_pkg::ntc_mid_t mid,
    output ntc_pkg::ntc_out_t out_item
);
    import ntc_pkg::*;

    logic               ddbl;
    logic [5:0]         fb;
    logic signed [13:0] bias;
    logic [63:0]        sbit;
    logic [63:0]        infv;
    logic signed [13:0] biased;
    logic signed [13:0] bm1;
    logic signed [13:0] shift;
    logic signed [13:0] fi_sh;
    logic [6:0]         sh7;
    logic [127:0]       t;
    logic [63:0]        kept;
    logic [63:0]        rounded;
    logic [63:0]        fpack;
    logic [63:0]        fres;
    logic [63:0]        dmask;
    logic [63:0]        smax;
    logic [63:0]        mag;
    logic               huge;
    logic [63:0]        res;
    logic               flag;

    always_comb
    begin
        ddbl = mid.dst_dbl;
        fb   = ddbl ? 6'd52 : 6'd23;
        bias = ddbl ? 14'sd1023 : 14'sd127;
        sbit = ddbl ? {mid.sign, 63'b0} : {32'b0, mid.sign, 31'b0};
        infv = sbit | (ddbl ? {1'b0, 11'h7FF, 52'b0} : {33'b0, 8'hFF, 23'b0});

        biased = mid.exp + bias;
        bm1    = biased - 14'sd1;
        shift  = 14'sd63 - $signed({8'b0, fb}) +
                 ((biased < 14'sd1) ? (14'sd1 - biased) : 14'sd0);
        fi_sh  = 14'sd63 - mid.exp;
        sh7    = (mid.mode == MODE_FI) ? fi_sh[6:0] : shift[6:0];

        // one shifter serves rounding and truncation
        t       = {mid.m, 64'b0} >> sh7;
        kept    = t[127:64];
        rounded = kept + {63'b0, t[63] && ((|t[62:0]) || kept[0])};

        if (mid.exp > bias)
            fpack = infv;
        else if (shift >= 14'sd65)
            fpack = sbit;
        else if (biased < 14'sd1)
            fpack = sbit | rounded;
        else
            fpack = sbit | (({50'b0, bm1} << fb) + rounded);

        case (mid.cls)
            CLS_ZERO: fres = sbit;
            CLS_INF:  fres = infv;
            CLS_NAN:  fres = ddbl ? (infv | (64'd1 << 51) | {mid.frac, 12'b0} >> 12 << 29)
                                  : (infv | (64'd1 << 22) | ({12'b0, mid.frac} >> 29));
            default:  fres = fpack;
        endcase

        dmask = size_mask(mid.dst_size_log2);
        smax  = dmask >> 1;
        huge  = (mid.cls == CLS_INF) ||
                ((mid.cls == CLS_FIN) && (mid.exp >= 14'sd64));
        mag   = ((mid.cls == CLS_FIN) && (mid.exp >= 14'sd0)) ? kept : 64'd0;

        flag = 1'b0;
        case (mid.mode)
            MODE_II: res = mid.raw;
            MODE_IF: res = fres;
            MODE_FF: res = (mid.src_dbl == mid.dst_dbl) ? mid.raw : fres;
            default:
            begin
                if (mid.cls == CLS_NAN)
                begin
                    flag = 1'b1;
                    res  = 64'd0;
                end
                else if (mid.dst_signed)
                begin
                    if (!mid.sign)
                    begin
                        flag = huge || (mag > smax);
                        res  = flag ? smax : mag;
                    end
                    else
                    begin
                        flag = huge || (mag > smax + 64'd1);
                        res  = flag ? smax + 64'd1 : (64'd0 - mag);
                    end
                end
                else if (mid.sign)
                begin
                    flag = huge || (mag != 64'd0);
                    res  = 64'd0;
                end
                else
                begin
                    flag = huge || (mag > dmask);
                    res  = flag ? dmask : mag;
                end
            end
        endcase

        if (mid.err)
        begin
            out_item.value_out  = 64'd0;
            out_item.range_flag = 1'b0;
            out_item.type_error = 1'b1;
        end
        else
        begin
            out_item.value_out  = res & dmask;
            out_item.range_flag = flag;
            out_item.type_error = 1'b0;
        end
    end

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Checks the numeric type converter core: a table of directed conversions,
// then random integer/float conversions, each checked against a behavioral
// converter model. Both handshakes see random idle bursts and one long
// output stall.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ntc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int NUM_RANDOM  = 700;
    localparam int TAIL_CYCLES = 10;

    typedef struct {
        ntc_in_t  conv;
        logic     has_exp;
        ntc_out_t exp_out;
    } conv_row_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_ready;
    ntc_in_t  in_data = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    ntc_out_t out_data;

    ntc_out_t  expected_q[$];
    conv_row_t conv_table[$];
    int        error_count = 0;
    int        cycle_count = 0;
    bit        stall_long = 1'b0;
    bit        quiet_tail = 1'b0;

    numeric_type_converter_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] width_mask(input int nbits);
        return (nbits >= 64) ? '1 : ((64'd1 << nbits) - 64'd1);
    endfunction

    // round-to-nearest-even pack of m * 2^(e-63), m[63] set
    function automatic logic [63:0] round_pack(input logic sgn, input int e,
                                               input logic [63:0] m, input bit dbl);
        int fb, eb, bias, biased, sh;
        logic [63:0] sbit, kept, rest;
        logic rb;
        fb = dbl ? 52 : 23;
        eb = dbl ? 11 : 8;
        bias = dbl ? 1023 : 127;
        sbit = 64'(sgn) << (fb + eb);
        if (e > bias)
            return sbit | (width_mask(eb) << fb);
        biased = e + bias;
        sh = 63 - fb;
        if (biased < 1)
            sh += 1 - biased;
        if (sh >= 65)
            return sbit;
        kept = (sh == 64) ? 64'd0 : (m >> sh);
        rb = m[sh - 1];
        rest = m & width_mask(sh - 1);
        if (rb && (rest != 0 || kept[0]))
            kept++;
        if (biased < 1)
            return sbit | kept;
        return sbit | ((64'(biased - 1) << fb) + kept);
    endfunction

    // splits a float into class, sign, normalized magnitude and exponent
    function automatic ntc_cls_t split_float(input logic [63:0] bits, input bit dbl,
                                             output logic sgn, output int e,
                                             output logic [63:0] m,
                                             output logic [63:0] frac);
        int fb, eb, bias, sh;
        logic [63:0] fld;
        fb = dbl ? 52 : 23;
        eb = dbl ? 11 : 8;
        bias = dbl ? 1023 : 127;
        fld = (bits >> fb) & width_mask(eb);
        frac = bits & width_mask(fb);
        sgn = bits[fb + eb];
        e = 0;
        m = 0;
        sh = 0;
        if (fld == width_mask(eb))
            return (frac != 0) ? CLS_NAN : CLS_INF;
        if (fld == 0 && frac == 0)
            return CLS_ZERO;
        if (fld != 0)
        begin
            m = frac | (64'd1 << fb);
            e = int'(fld) - bias;
        end
        else
        begin
            m = frac;
            e = 1 - bias;
        end
        while (!m[63])
        begin
            m <<= 1;
            sh++;
        end
        e = e + (63 - sh) - fb;
        return CLS_FIN;
    endfunction

    function automatic ntc_out_t convert(input ntc_in_t c);
        ntc_out_t r;
        int sbits, dbits, e, pos;
        logic [63:0] v, m, frac, mag, umax, smax;
        logic sgn, huge;
        bit sdbl, ddbl;
        ntc_cls_t cls;
        r = '0;
        sbits = 8 << c.src_size_log2;
        dbits = 8 << c.dst_size_log2;
        sdbl = (sbits == 64);
        ddbl = (dbits == 64);
        v = c.value_in & width_mask(sbits);
        if ((c.src_is_float && sbits < 32) || (c.dst_is_float && dbits < 32))
        begin
            r.type_error = 1'b1;
            return r;
        end
        if (!c.src_is_float && !c.dst_is_float)
        begin
            if (c.src_signed && sbits < 64 && v[sbits - 1])
                v |= ~width_mask(sbits);
            r.value_out = v;
        end
        else if (!c.src_is_float)
        begin
            mag = v;
            sgn = 1'b0;
            pos = 63;
            if (c.src_signed && v[sbits - 1])
            begin
                sgn = 1'b1;
                mag = (64'd0 - v) & width_mask(sbits);
                if (mag == 0)
                    mag = 64'd1 << (sbits - 1);
            end
            if (mag == 0)
                r.value_out = 0;
            else
            begin
                while (!mag[63])
                begin
                    mag <<= 1;
                    pos--;
                end
                r.value_out = round_pack(sgn, pos, mag, ddbl);
            end
        end
        else if (c.dst_is_float)
        begin
            if (sdbl == ddbl)
                r.value_out = v;
            else
            begin
                cls = split_float(v, sdbl, sgn, e, m, frac);
                if (ddbl)
                    case (cls)
                        CLS_ZERO: r.value_out = 64'(sgn) << 63;
                        CLS_INF:  r.value_out = (64'(sgn) << 63) | (64'h7FF << 52);
                        CLS_NAN:  r.value_out = (64'(sgn) << 63) | (64'h7FF << 52)
                                              | (64'd1 << 51) | (frac << 29);
                        default:  r.value_out = round_pack(sgn, e, m, 1'b1);
                    endcase
                else
                    case (cls)
                        CLS_ZERO: r.value_out = 64'(sgn) << 31;
                        CLS_INF:  r.value_out = (64'(sgn) << 31) | (64'hFF << 23);
                        CLS_NAN:  r.value_out = (64'(sgn) << 31) | (64'hFF << 23)
                                              | (64'd1 << 22) | (frac >> 29);
                        default:  r.value_out = round_pack(sgn, e, m, 1'b0);
                    endcase
            end
        end
        else
        begin
            umax = width_mask(dbits);
            smax = umax >> 1;
            mag = 0;
            huge = 1'b0;
            cls = split_float(v, sdbl, sgn, e, m, frac);
            if (cls == CLS_NAN)
            begin
                r.range_flag = 1'b1;
                return r;
            end
            if (cls == CLS_INF)
                huge = 1'b1;
            else if (cls == CLS_FIN)
            begin
                if (e >= 64)
                    huge = 1'b1;
                else if (e >= 0)
                    mag = m >> (63 - e);
            end
            if (c.dst_signed)
            begin
                if (!sgn)
                begin
                    if (huge || mag > smax)
                    begin
                        r.range_flag = 1'b1;
                        r.value_out = smax;
                    end
                    else
                        r.value_out = mag;
                end
                else if (huge || mag > smax + 1)
                begin
                    r.range_flag = 1'b1;
                    r.value_out = smax + 1;
                end
                else
                    r.value_out = (64'd0 - mag) & umax;
            end
            else if (sgn)
            begin
                r.range_flag = huge || mag != 0;
                r.value_out = 0;
            end
            else if (huge || mag > umax)
            begin
                r.range_flag = 1'b1;
                r.value_out = umax;
            end
            else
                r.value_out = mag;
        end
        r.value_out &= width_mask(dbits);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    task automatic add_row(input logic [63:0] v, input logic sf, input logic [1:0] ss,
                           input logic sgs, input logic df, input logic [1:0] ds,
                           input logic sgd, input logic has_exp = 1'b0,
                           input logic [63:0] ev = 0, input logic ef = 0,
                           input logic ee = 0);
        conv_row_t row;
        row.conv = '{v, sf, ss, sgs, df, ds, sgd};
        row.has_exp = has_exp;
        row.exp_out = '{ev, ef, ee};
        conv_table.push_back(row);
    endtask

    function automatic ntc_in_t random_conv();
        ntc_in_t c;
        int kind;
        c.value_in = {$urandom, $urandom};
        c.src_is_float = 1'($urandom_range(0, 1));
        c.dst_is_float = 1'($urandom_range(0, 1));
        c.src_size_log2 = 2'($urandom_range(0, 3));
        c.dst_size_log2 = 2'($urandom_range(0, 3));
        c.src_signed = 1'($urandom_range(0, 1));
        c.dst_signed = 1'($urandom_range(0, 1));
        // keep most float sizes legal so conversions go deep
        if ($urandom_range(0, 9) != 0)
        begin
            if (c.src_is_float)
                c.src_size_log2 = 2'($urandom_range(SZ_4B, SZ_8B));
            if (c.dst_is_float)
                c.dst_size_log2 = 2'($urandom_range(SZ_4B, SZ_8B));
        end
        kind = $urandom_range(0, 7);
        if (c.src_is_float && kind < 4)
        begin
            // exponents near the integer range, subnormals, specials
            if (c.src_size_log2 == SZ_8B)
            begin
                case (kind)
                    0: c.value_in[62:52] = 11'(1023 + $urandom_range(0, 66));
                    1: c.value_in[62:52] = $urandom_range(0, 1) ? 11'h7FF : 11'h000;
                    2: c.value_in[62:52] = 11'($urandom_range(0, 2) + 1022);
                    default: c.value_in[62:52] = 11'(1223 - $urandom_range(0, 200));
                endcase
            end
            else
            begin
                case (kind)
                    0: c.value_in[30:23] = 8'(127 + $urandom_range(0, 66));
                    1: c.value_in[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    2: c.value_in[30:23] = 8'($urandom_range(0, 2) + 126);
                    default: c.value_in[30:23] = 8'(170 - $urandom_range(0, 100));
                endcase
                if (kind == 1 && $urandom_range(0, 1))
                    c.value_in[22:0] = '0;
            end
        end
        else if (!c.src_is_float && kind == 4)
            c.value_in = 64'd1 << $urandom_range(0, 63);
        return c;
    endfunction

    task automatic send(input ntc_in_t c, input bit idle_ok);
        int gap;
        if (idle_ok && !quiet_tail && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= c;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_q.push_back(convert(c));
    endtask

    // output side: random short stalls, one long stall on request
    always @(posedge clk)
    begin
        if (!rst_n || stall_long)
            out_ready <= 1'b0;
        else if (quiet_tail)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 4) != 0);
    end

    always @(posedge clk)
    begin
        ntc_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
                report_mismatch("unexpected transaction", out_data.value_out, 64'd0);
            else
            begin
                want = expected_q.pop_front();
                if (out_data.value_out !== want.value_out)
                    report_mismatch("value_out", out_data.value_out, want.value_out);
                if (out_data.range_flag !== want.range_flag)
                    report_mismatch("range_flag", 64'(out_data.range_flag),
                                    64'(want.range_flag));
                if (out_data.type_error !== want.type_error)
                    report_mismatch("type_error", 64'(out_data.type_error),
                                    64'(want.type_error));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        ntc_out_t want;
        int k;
        // special cases with results readable by eye
        add_row(64'hFF, 0, SZ_1B, 1, 0, SZ_8B, 1, 1, 64'hFFFF_FFFF_FFFF_FFFF);
        add_row(64'hFF, 0, SZ_1B, 0, 0, SZ_8B, 0, 1, 64'h0000_0000_0000_00FF);
        add_row(64'h1234_5678_9ABC_DEF0, 0, SZ_8B, 0, 0, SZ_1B, 0, 1, 64'hF0);
        add_row(64'h1234, 1, SZ_2B, 0, 0, SZ_4B, 0, 1, 0, 0, 1);
        add_row(64'h1234, 0, SZ_4B, 0, 1, SZ_1B, 0, 1, 0, 0, 1);
        add_row(64'h7FC0_0000, 1, SZ_4B, 0, 0, SZ_4B, 1, 1, 0, 1, 0);
        add_row(64'h7F80_0000, 1, SZ_4B, 0, 0, SZ_4B, 1, 1, 64'h7FFF_FFFF, 1, 0);
        add_row(64'hFF80_0000, 1, SZ_4B, 0, 0, SZ_4B, 1, 1, 64'h8000_0000, 1, 0);
        add_row(64'hFF80_0000, 1, SZ_4B, 0, 0, SZ_2B, 0, 1, 0, 1, 0);
        add_row(64'h7FF0_0000_0000_0000, 1, SZ_8B, 0, 0, SZ_8B, 0, 1, '1, 1, 0);
        add_row(64'hBF00_0000, 1, SZ_4B, 0, 0, SZ_1B, 0, 1, 0, 0, 0);
        add_row(64'hDEAD_4049_0FDB, 1, SZ_4B, 0, 1, SZ_4B, 0, 1, 64'h4049_0FDB);
        add_row(64'h7FA0_0001, 1, SZ_4B, 0, 1, SZ_8B, 0);
        add_row(64'h7FF4_0000_0000_1234, 1, SZ_8B, 0, 1, SZ_4B, 0);
        add_row(64'h0000_0000_0000_0001, 1, SZ_8B, 0, 1, SZ_4B, 0);
        add_row(64'h47EF_FFFF_F000_0000, 1, SZ_8B, 0, 1, SZ_4B, 0);
        add_row(64'h0000_0001, 1, SZ_4B, 0, 1, SZ_8B, 0);
        add_row(64'h8000_0000_0000_0000, 0, SZ_8B, 1, 1, SZ_4B, 0);
        add_row(64'hFFFF_FFFF_FFFF_FFFF, 0, SZ_8B, 0, 1, SZ_8B, 0);
        add_row(64'h0100_0001, 0, SZ_4B, 0, 1, SZ_4B, 0);
        add_row(64'h80, 0, SZ_1B, 1, 1, SZ_8B, 0);
        add_row(64'h0, 0, SZ_2B, 1, 1, SZ_4B, 0, 1, 0);
        add_row(64'h41DF_FFFF_FFC0_0000, 1, SZ_8B, 0, 0, SZ_4B, 1);
        add_row(64'hC3E0_0000_0000_0000, 1, SZ_8B, 0, 0, SZ_8B, 1);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (conv_table[i])
        begin
            if (conv_table[i].has_exp)
            begin
                want = convert(conv_table[i].conv);
                if (want !== conv_table[i].exp_out)
                    report_mismatch($sformatf("table row %0d", i), want.value_out,
                                    conv_table[i].exp_out.value_out);
            end
            send(conv_table[i].conv, 1'b1);
        end

        // long output stall while the input keeps offering
        stall_long = 1'b1;
        fork
            repeat (40) @(posedge clk);
            for (k = 0; k < 12; k++)
                send(random_conv(), 1'b0);
        join_any
        stall_long = 1'b0;
        wait fork;

        for (k = 0; k < NUM_RANDOM; k++)
        begin
            if (k == NUM_RANDOM / 2)
            begin
                // sender pause until the pipe drains
                in_valid <= 1'b0;
                while (expected_q.size() != 0)
                    @(posedge clk);
            end
            if (k == NUM_RANDOM - 100)
                quiet_tail = 1'b1;
            send(random_conv(), 1'b1);
        end
        in_valid <= 1'b0;

        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
